// File: design/wdm_pkg.sv
// Package of the wavetable mixer: field widths, command, waveform and register codes,
// the configuration record and the frequency-to-step request record. No dependencies.
`timescale 1ns / 1ps

package wdm_pkg;

   localparam int unsigned OSCILLATORS_DEFAULT = 2;
   localparam int unsigned VOLUME_MAX_DEFAULT  = 255;
   localparam int unsigned CLOCK_HZ_DEFAULT    = 16000000;
   localparam int unsigned TABLE_DEPTH         = 256;

   localparam int unsigned VOICE_REGS   = 2;
   localparam int unsigned FREQ_W       = 16;
   localparam int unsigned PHASE_W      = 16;
   localparam int unsigned SAMPLE_W     = 8;
   localparam int unsigned TABLE_IDX_W  = $clog2(TABLE_DEPTH);
   localparam int unsigned MEM_ADDR_W   = TABLE_IDX_W + 1;
   localparam int unsigned MEM_DEPTH    = 2 * TABLE_DEPTH;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned DIVIDEND_W   = 32;
   localparam int unsigned RATE_SHIFT   = 256;
   localparam int unsigned RECIP_SHIFT  = 24;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] WAVE_NONE = 2'd0;
   localparam logic [1:0] WAVE_SINE = 2'd1;
   localparam logic [1:0] WAVE_SAW  = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FREQ_A   = 3'd0,
      REG_FREQ_B   = 3'd1,
      REG_VOLUME_A = 3'd2,
      REG_VOLUME_B = 3'd3,
      REG_WAVE_A   = 3'd4,
      REG_WAVE_B   = 3'd5
   } wdm_reg_type;

   typedef struct packed {
      logic [VOICE_REGS-1:0][FREQ_W-1:0]   freq;
      logic [VOICE_REGS-1:0][SAMPLE_W-1:0] volume;
      logic [VOICE_REGS-1:0][1:0]          wave;
   } wdm_cfg_type;

   typedef struct packed {
      logic              start;
      logic              osc;
      logic [FREQ_W-1:0] freq;
   } wdm_div_req_type;

endpackage

// File: design/wdm_step_div.sv
// Frequency-to-step converter: a multiply by the reciprocal of the rate constant
// that turns a written frequency into a phase step in the cycle after the write. Depends on wdm_pkg.
`timescale 1ns / 1ps

module wdm_step_div #(
   parameter int unsigned CLOCK_HZ = wdm_pkg::CLOCK_HZ_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  wdm_pkg::wdm_div_req_type                              div_req,
   output logic                                                  busy,
   output logic [wdm_pkg::VOICE_REGS-1:0][wdm_pkg::PHASE_W-1:0]  step
);
   import wdm_pkg::*;

   localparam int unsigned RATE_RAW = CLOCK_HZ / RATE_SHIFT;
   localparam int unsigned RATE     = (RATE_RAW == 0) ? 1 : RATE_RAW;
   localparam int unsigned RECIP_K  = DIVIDEND_W + $clog2(RATE);
   localparam longint unsigned RECIP = ((64'd1 << RECIP_K) + RATE - 1) / RATE;
   localparam int unsigned RECIP_W  = $clog2(RECIP + 1);
   localparam int unsigned SEL      = FREQ_W + $clog2(RATE);
   localparam int unsigned MUL_W    = (FREQ_W + RECIP_W > SEL + PHASE_W) ?
                                      FREQ_W + RECIP_W : SEL + PHASE_W;

   logic                 busy_ff;
   logic                 osc_ff;
   logic [FREQ_W-1:0]    freq_ff;
   logic [VOICE_REGS-1:0][PHASE_W-1:0] step_ff;
   logic [MUL_W-1:0]     prod;

   assign prod = MUL_W'(freq_ff) * MUL_W'(RECIP_W'(RECIP));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (div_req.start && !busy_ff) begin
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         busy_ff         <= 1'b0;
         step_ff[osc_ff] <= prod[SEL +: PHASE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start && !busy_ff) begin
         osc_ff  <= div_req.osc;
         freq_ff <= div_req.freq;
      end
   end

   assign busy = busy_ff;
   assign step = step_ff;

endmodule

// File: design/wdm_csr.sv
// Configuration registers of the mixer and the trigger of the step converter
// on a frequency write. Depends on wdm_pkg.
`timescale 1ns / 1ps

module wdm_csr #(
   parameter int unsigned OSCILLATORS = wdm_pkg::OSCILLATORS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [wdm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wdm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              busy,
   output logic                              csr_ready,
   output wdm_pkg::wdm_cfg_type              cfg,
   output wdm_pkg::wdm_div_req_type          div_req
);
   import wdm_pkg::*;

   wdm_cfg_type cfg_ff;
   logic        wr;

   assign csr_ready = !busy;
   assign wr        = csr_valid && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr) begin
         unique case (csr_index)
            REG_FREQ_A:   cfg_ff.freq[0]   <= csr_wdata[FREQ_W-1:0];
            REG_FREQ_B:   cfg_ff.freq[1]   <= csr_wdata[FREQ_W-1:0];
            REG_VOLUME_A: cfg_ff.volume[0] <= csr_wdata[SAMPLE_W-1:0];
            REG_VOLUME_B: cfg_ff.volume[1] <= csr_wdata[SAMPLE_W-1:0];
            REG_WAVE_A:   cfg_ff.wave[0]   <= csr_wdata[1:0];
            REG_WAVE_B:   cfg_ff.wave[1]   <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      div_req.start = wr && ((csr_index == REG_FREQ_A)
                      || ((csr_index == REG_FREQ_B) && (OSCILLATORS > 1)));
      div_req.osc   = (csr_index == REG_FREQ_B);
      div_req.freq  = csr_wdata[FREQ_W-1:0];
   end

   assign cfg = cfg_ff;

endmodule

// File: design/wdm_wave_mem.sv
// Sine and saw tables in one memory, one write port and one registered read port
// for each oscillator. Depends on wdm_pkg.
`timescale 1ns / 1ps

module wdm_wave_mem #(
   parameter int unsigned PORTS = wdm_pkg::OSCILLATORS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             we,
   input  logic [wdm_pkg::MEM_ADDR_W-1:0]                   waddr,
   input  logic [wdm_pkg::SAMPLE_W-1:0]                     wdata,
   input  logic                                             re,
   input  logic [PORTS-1:0][wdm_pkg::MEM_ADDR_W-1:0]        raddr,
   output logic [PORTS-1:0][wdm_pkg::SAMPLE_W-1:0]          rdata
);
   import wdm_pkg::*;

   logic [SAMPLE_W-1:0] mem_ff [0:MEM_DEPTH-1];
   logic [PORTS-1:0][SAMPLE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   for (genvar p = 0; p < PORTS; p++) begin : g_port
      always_ff @(posedge clock) begin
         if (re) begin
            rdata_ff[p] <= mem_ff[raddr[p]];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/wdm_voice.sv
// Gain stage of one oscillator: registered table value times volume, then a
// reciprocal multiply that divides by the full-scale volume. Depends on wdm_pkg.
`timescale 1ns / 1ps

module wdm_voice #(
   parameter int unsigned VOLUME_MAX = wdm_pkg::VOLUME_MAX_DEFAULT
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           active,
   input  logic [wdm_pkg::SAMPLE_W-1:0]   raw,
   input  logic [wdm_pkg::SAMPLE_W-1:0]   volume,
   output logic [wdm_pkg::SAMPLE_W-1:0]   scaled
);
   import wdm_pkg::*;

   localparam int unsigned PROD_W  = 2 * SAMPLE_W;
   localparam longint unsigned ONE = 64'd1 << RECIP_SHIFT;
   localparam longint unsigned RECIP = (ONE + VOLUME_MAX - 1) / VOLUME_MAX;
   localparam int unsigned RECIP_W = RECIP_SHIFT + 1;
   localparam int unsigned FULL_W  = PROD_W + RECIP_W;

   logic [PROD_W-1:0] prod_ff;
   logic [FULL_W-1:0] full;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= active ? PROD_W'(raw) * PROD_W'(volume) : '0;
      end
   end

   assign full   = FULL_W'(prod_ff) * FULL_W'(RECIP_W'(RECIP));
   assign scaled = full[RECIP_SHIFT +: SAMPLE_W];

endmodule

// File: design/wavetable_dds_mixer.sv
// Wavetable oscillator mixer. A request either writes one byte of the sine or saw
// table or is a tick that advances every oscillator's phase and returns one mixed
// sample. One request is taken in every cycle while requests are not stalled. A tick's
// sample passes the table read, gain product and scaling and sum registers in that order
// before it is presented, and a waiting sample stalls requests only once all three stages
// are full. A write to a frequency register loads the phase step through a reciprocal
// multiply in the following cycle; during that cycle requests are stalled and the
// configuration port is not ready.
// Depends on wdm_pkg, wdm_csr, wdm_step_div, wdm_wave_mem and wdm_voice.
`timescale 1ns / 1ps

module wavetable_dds_mixer #(
   parameter int unsigned OSCILLATORS = wdm_pkg::OSCILLATORS_DEFAULT,
   parameter int unsigned VOLUME_MAX  = wdm_pkg::VOLUME_MAX_DEFAULT,
   parameter int unsigned CLOCK_HZ    = wdm_pkg::CLOCK_HZ_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic                              req_table_select,
   input  logic [wdm_pkg::TABLE_IDX_W-1:0]   req_table_index,
   input  logic [wdm_pkg::SAMPLE_W-1:0]      req_table_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wdm_pkg::SAMPLE_W-1:0]      rsp_sample,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wdm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wdm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wdm_pkg::*;

   wdm_cfg_type     cfg;
   wdm_div_req_type div_req;
   logic            busy;
   logic [VOICE_REGS-1:0][PHASE_W-1:0] step;

   logic [OSCILLATORS-1:0][PHASE_W-1:0]    phase_ff;
   logic [OSCILLATORS-1:0][PHASE_W-1:0]    phase_in;
   logic [OSCILLATORS-1:0][MEM_ADDR_W-1:0] raddr;
   logic [OSCILLATORS-1:0][SAMPLE_W-1:0]   raw;
   logic [OSCILLATORS-1:0][SAMPLE_W-1:0]   scaled;
   logic [OSCILLATORS-1:0]                 act1_ff;

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   logic tick_acc, write_acc;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] mix;

   wdm_csr #(
      .OSCILLATORS(OSCILLATORS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .busy     (busy),
      .csr_ready(csr_ready),
      .cfg      (cfg),
      .div_req  (div_req)
   );

   wdm_step_div #(
      .CLOCK_HZ(CLOCK_HZ)
   ) u_step_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .busy   (busy),
      .step   (step)
   );

   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = busy || !en1;
   assign tick_acc  = req_valid && !req_stall && (req_command == CMD_TICK);
   assign write_acc = req_valid && !req_stall && (req_command == CMD_WRITE);

   for (genvar i = 0; i < OSCILLATORS; i++) begin : g_osc
      assign phase_in[i] = phase_ff[i] + step[i];
      assign raddr[i]    = {(cfg.wave[i] == WAVE_SAW), phase_in[i][PHASE_W-1 -: TABLE_IDX_W]};

      always_ff @(posedge clock) begin
         if (reset) begin
            phase_ff[i] <= '0;
         end else if (tick_acc) begin
            phase_ff[i] <= phase_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (tick_acc) begin
            act1_ff[i] <= (cfg.wave[i] == WAVE_SINE) || (cfg.wave[i] == WAVE_SAW);
         end
      end

      wdm_voice #(
         .VOLUME_MAX(VOLUME_MAX)
      ) u_voice (
         .clock (clock),
         .load  (en2 && v1_ff),
         .active(act1_ff[i]),
         .raw   (raw[i]),
         .volume(cfg.volume[i]),
         .scaled(scaled[i])
      );
   end

   wdm_wave_mem #(
      .PORTS(OSCILLATORS)
   ) u_wave_mem (
      .clock(clock),
      .we   (write_acc),
      .waddr({req_table_select, req_table_index}),
      .wdata(req_table_value),
      .re   (tick_acc),
      .raddr(raddr),
      .rdata(raw)
   );

   always_comb begin
      mix = '0;
      for (int i = 0; i < OSCILLATORS; i++) begin
         mix = mix + scaled[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= tick_acc;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         sample_ff <= mix;
      end
   end

   assign rsp_valid  = v3_ff;
   assign rsp_sample = sample_ff;

endmodule

// File: design/wdm_checker.sv
// Port-level checks of the wavetable mixer, bound to its top level.
// Depends on wdm_pkg and wavetable_dds_mixer.
`timescale 1ns / 1ps

module wdm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_command,
   input logic                              req_table_select,
   input logic [wdm_pkg::TABLE_IDX_W-1:0]   req_table_index,
   input logic [wdm_pkg::SAMPLE_W-1:0]      req_table_value,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [wdm_pkg::SAMPLE_W-1:0]      rsp_sample,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [wdm_pkg::CSR_INDEX_W-1:0]   csr_index
);
   import wdm_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_command)
         && $stable(req_table_select) && $stable(req_table_index)
         && $stable(req_table_value))
      else $error("stalled request changed or dropped");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled sample changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("sample present after reset");

   a_freq_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == REG_FREQ_A) |=> !csr_ready && req_stall)
      else $error("frequency write did not start the step converter");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      !csr_ready |-> req_stall)
      else $error("request taken while the step converter runs");

endmodule

bind wavetable_dds_mixer wdm_checker u_wdm_checker (.*);
